@@ rtl/gbn_pkg.sv @@
package gbn_pkg;

    // Default sizing
    localparam int DEF_WINDOW   = 16;
    localparam int DEF_SEQ_BITS = 16;

    // Register map (index = byte address / 4)
    localparam logic [0:0]  REG_TIMEOUT   = 1'b0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // Input opcodes
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_NEW     = 2'd0;
    localparam logic [1:0] KIND_RETX    = 2'd1;
    localparam logic [1:0] KIND_REFUSED = 2'd2;
    localparam logic [1:0] KIND_ACK     = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] seg_flags;
        logic [15:0] data_len;
        logic [15:0] payload_tag;
        logic [15:0] ack_num;
        logic        checksum_ok;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] seq_num;
        logic [15:0] out_flags;
        logic [15:0] out_len;
        logic [15:0] out_tag;
        logic [4:0]  outstanding;
        logic        last;
    } out_word_t;

    // Decoded command handed from front to back
    typedef enum logic [1:0] {
        CMD_SEND,
        CMD_ACK,
        CMD_TICK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [15:0] flags;
        logic [15:0] len;
        logic [15:0] tag;
        logic [15:0] ack_num;
        logic        checksum_ok;
    } cmd_t;

    // Descriptor held in the ring
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] flags;
        logic [15:0] len;
    } slot_t;

endpackage

@@ rtl/gbn_front.sv @@
module gbn_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gbn_pkg::in_word_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output gbn_pkg::cmd_t     cmd
);
    import gbn_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop, known;
    cmd_t       decoded;

    // Classify the incoming word; unknown opcodes are dropped here
    always_comb begin
        decoded.flags       = s_data.seg_flags;
        decoded.len         = s_data.data_len;
        decoded.tag         = s_data.payload_tag;
        decoded.ack_num     = s_data.ack_num;
        decoded.checksum_ok = s_data.checksum_ok;
        decoded.op          = CMD_TICK;
        known               = 1'b1;
        case (s_data.opcode)
            OP_SEND: decoded.op = CMD_SEND;
            OP_ACK:  decoded.op = CMD_ACK;
            OP_TICK: decoded.op = CMD_TICK;
            default: known = 1'b0;
        endcase
    end

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready && known;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // Queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

    a_fill_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue fill level did not follow a lone push");

endmodule

@@ rtl/gbn_back.sv @@
module gbn_back #(
    parameter int WINDOW   = gbn_pkg::DEF_WINDOW,
    parameter int SEQ_BITS = gbn_pkg::DEF_SEQ_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  gbn_pkg::cmd_t      cmd,
    input  logic [15:0]        timeout_ticks,
    output logic               m_valid,
    input  logic               m_ready,
    output gbn_pkg::out_word_t m_data
);
    import gbn_pkg::*;

    localparam int SB      = SEQ_BITS;
    localparam int IDXW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW      = $clog2(WINDOW + 1);
    localparam int SEQ_MAX = (1 << SEQ_BITS) - 1;
    localparam int WIN_EFF = (WINDOW < SEQ_MAX) ? WINDOW : SEQ_MAX;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [SB-1:0]     base_reg, base_next;
    logic [SB-1:0]     next_reg, next_next;
    logic [15:0]       wait_reg, wait_next;
    logic              timer_reg, timer_next;
    logic [IDXW-1:0]   head_reg, head_next;
    logic [IDXW-1:0]   rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    slot_t             mem [WINDOW];
    slot_t             rdata_reg;
    logic              mem_we;
    logic [IDXW-1:0]   mem_waddr;
    slot_t             mem_wdata;

    logic              out_free;
    logic              out_load;
    out_word_t         out_word;
    logic [SB-1:0]     outs;
    logic [CW-1:0]     outs_c;
    logic [SB-1:0]     ack_d;
    logic [SB-1:0]     base_new;
    logic [15:0]       wc_inc;
    logic [CW:0]       idx_sum;
    logic              sweep_last;

    // Low five bits of a count, zero extended when SEQ_BITS is narrow
    function automatic logic [4:0] cnt5(input logic [SB-1:0] v);
        logic [15:0] e;
        e = 16'(v);
        return e[4:0];
    endfunction

    assign outs      = next_reg - base_reg;
    assign outs_c    = CW'(outs);
    assign ack_d     = SB'(cmd.ack_num) - base_reg;
    assign base_new  = base_reg + ack_d + SB'(1);
    assign wc_inc    = wait_reg + 16'd1;
    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && out_free;
    assign sweep_last = ((CW + 1)'(cnt_reg) + (CW + 1)'(1)) == (CW + 1)'(outs_c);

    // Command execution and resend sweep
    always_comb begin
        state_next  = state_reg;
        base_next   = base_reg;
        next_next   = next_reg;
        wait_next   = wait_reg;
        timer_next  = timer_reg;
        head_next   = head_reg;
        rd_idx_next = rd_idx_reg;
        cnt_next    = cnt_reg;
        mem_we      = 1'b0;
        mem_waddr   = head_reg;
        mem_wdata   = '{tag: cmd.tag, flags: cmd.flags, len: cmd.len};
        out_load    = 1'b0;
        out_word    = '0;
        idx_sum     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    case (cmd.op)
                        CMD_SEND: begin
                            out_load      = 1'b1;
                            out_word.last = 1'b1;
                            if (outs >= SB'(WIN_EFF)) begin
                                out_word.kind        = KIND_REFUSED;
                                out_word.seq_num     = 16'(next_reg);
                                out_word.outstanding = cnt5(outs);
                            end else begin
                                // slot of next_reg in the ring
                                idx_sum = (CW + 1)'(head_reg) + (CW + 1)'(outs_c);
                                if (idx_sum >= (CW + 1)'(WINDOW)) begin
                                    idx_sum = idx_sum - (CW + 1)'(WINDOW);
                                end
                                mem_we    = 1'b1;
                                mem_waddr = IDXW'(idx_sum);
                                if (outs == '0) begin
                                    wait_next  = 16'd0;
                                    timer_next = 1'b1;
                                end
                                next_next            = next_reg + SB'(1);
                                out_word.kind        = KIND_NEW;
                                out_word.seq_num     = 16'(next_reg);
                                out_word.out_flags   = cmd.flags;
                                out_word.out_len     = cmd.len;
                                out_word.out_tag     = cmd.tag;
                                out_word.outstanding = cnt5(outs + SB'(1));
                            end
                        end
                        CMD_ACK: begin
                            out_load             = 1'b1;
                            out_word.kind        = KIND_ACK;
                            out_word.last        = 1'b1;
                            out_word.seq_num     = 16'(base_reg);
                            out_word.outstanding = cnt5(outs);
                            if (cmd.checksum_ok && (ack_d < outs)) begin
                                // cumulative release up to ack_num
                                idx_sum = (CW + 1)'(head_reg) + (CW + 1)'(CW'(ack_d))
                                        + (CW + 1)'(1);
                                if (idx_sum >= (CW + 1)'(WINDOW)) begin
                                    idx_sum = idx_sum - (CW + 1)'(WINDOW);
                                end
                                head_next            = IDXW'(idx_sum);
                                base_next            = base_new;
                                wait_next            = 16'd0;
                                timer_next           = (base_new != next_reg);
                                out_word.seq_num     = 16'(base_new);
                                out_word.outstanding = cnt5(next_reg - base_new);
                            end
                        end
                        CMD_TICK: begin
                            if (timer_reg) begin
                                if (wc_inc < timeout_ticks) begin
                                    wait_next = wc_inc;
                                end else begin
                                    wait_next = 16'd0;
                                    if (outs != '0) begin
                                        state_next  = ST_READ;
                                        cnt_next    = '0;
                                        rd_idx_next = head_reg;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_word.kind        = KIND_RETX;
                    out_word.seq_num     = 16'(base_reg + SB'(cnt_reg));
                    out_word.out_flags   = rdata_reg.flags;
                    out_word.out_len     = rdata_reg.len;
                    out_word.out_tag     = rdata_reg.tag;
                    out_word.outstanding = cnt5(outs);
                    out_word.last        = sweep_last;
                    cnt_next             = cnt_reg + CW'(1);
                    if (rd_idx_reg == IDXW'(WINDOW - 1)) begin
                        rd_idx_next = '0;
                    end else begin
                        rd_idx_next = rd_idx_reg + IDXW'(1);
                    end
                    state_next = sweep_last ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = out_word;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            base_reg    <= '0;
            next_reg    <= '0;
            wait_reg    <= 16'd0;
            timer_reg   <= 1'b0;
            head_reg    <= '0;
            rd_idx_reg  <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            next_reg    <= next_next;
            wait_reg    <= wait_next;
            timer_reg   <= timer_next;
            head_reg    <= head_next;
            rd_idx_reg  <= rd_idx_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // Descriptor ring
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_idx_reg];
    end

    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        outs <= SB'(WIN_EFF))
        else $error("more segments outstanding than the window allows");

    a_timer_needs_outs: assert property (@(posedge aclk) disable iff (!aresetn)
        timer_reg |-> (outs != '0))
        else $error("retransmit timer running with an empty window");

    a_sweep_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> ((CW + 1)'(cnt_reg) < (CW + 1)'(outs_c)))
        else $error("resend sweep ran past the outstanding segments");

    a_sweep_holds_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |=> $stable(base_reg) && $stable(next_reg))
        else $error("window moved during a resend sweep");

endmodule

@@ rtl/go_back_n_sender_window.sv @@
// Go-Back-N sender window. Words on s_* are sends (opcode 0), acks (1) or timer
// ticks (2); opcode 3 is dropped. A front stage decodes each word into a
// two-entry command queue, so s_ready stays high while the queue has room; a
// back stage executes one command per cycle whenever its output register is
// free and no resend sweep is running. A send or an ack yields one word on m_*,
// via the queue and the output register; a tick yields nothing unless the timer
// expires, in which case every outstanding descriptor is resent from the ring
// memory, oldest first (a registered read, then an output load each), with last
// set on the final one. timeout_ticks sits at byte address 0 of the APB port
// (reset 1000, a value of 0 acts as 1) and should be written only while idle.
module go_back_n_sender_window #(
    parameter int WINDOW   = gbn_pkg::DEF_WINDOW,
    parameter int SEQ_BITS = gbn_pkg::DEF_SEQ_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gbn_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gbn_pkg::out_word_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import gbn_pkg::*;

    logic [15:0] timeout_reg, timeout_next;
    logic        cmd_valid, cmd_ready;
    cmd_t        cmd;
    logic        reg_hit;

    // Config register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2:2] == REG_TIMEOUT);
    assign prdata  = reg_hit ? 32'(timeout_reg) : 32'd0;

    always_comb begin
        timeout_next = timeout_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            timeout_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            timeout_reg <= timeout_next;
        end
    end

    gbn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    gbn_back #(
        .WINDOW   (WINDOW),
        .SEQ_BITS (SEQ_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .timeout_ticks (timeout_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule
